/* design/dldr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dldr_pkg: shared types and constants of the dark-light-dark run detector
// Holds the circle buffer sizing, register codes, reset values and the
// report item that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package dldr_pkg;

  // Circle buffer sizing
  localparam int MAX_CIRCLE_POINTS = 1024;
  localparam int IDX_W = $clog2(MAX_CIRCLE_POINTS);
  localparam int CNT_W = $clog2(MAX_CIRCLE_POINTS + 1);

  // One stored point: x, y, gray
  localparam int STORE_W = 28;

  // Report queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_JUMP_SIZE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_LEVEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RUN_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y       = 3'd5;

  localparam logic [7:0] RST_JUMP_SIZE      = 8'd20;
  localparam logic [7:0] RST_DARK_THRESHOLD = 8'd80;
  localparam logic [7:0] RST_FLOOR_LEVEL    = 8'd100;
  localparam logic [9:0] RST_MIN_RUN_WIDTH  = 10'd5;
  localparam logic [9:0] RST_CENTRE_X       = 10'd320;
  localparam logic [9:0] RST_CENTRE_Y       = 10'd240;

  // Mark value: dark midpoint gives full mark
  localparam logic [7:0] MARK_DARK_LIMIT = 8'd60;
  localparam logic [7:0] MARK_ON         = 8'd255;
  localparam logic [7:0] MARK_OFF        = 8'd0;

  // Configuration register file
  typedef struct packed {
    logic [7:0] jump_size;
    logic [7:0] dark_threshold;
    logic [7:0] floor_level;
    logic [9:0] min_run_width;
    logic [9:0] centre_x;
    logic [9:0] centre_y;
  } cfg_t;

  // Report item: buffered midpoint and its index
  typedef struct packed {
    logic [9:0] pos_x;
    logic [9:0] pos_y;
    logic [7:0] gray;
    logic [9:0] mid_index;
  } job_t;

endpackage

/* design/dldr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dldr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dldr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/dldr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dldr_front: sample classifier and circle buffer
// Accepts one sample per cycle unless stalled, stores it, tracks the dark-light run and,
// on a wide enough run, reads the midpoint back and queues a report.
// ----------------------------------------------------------------------------
module dldr_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dldr_pkg::cfg_t            cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                gray_i,
  input  logic [9:0]                pos_x_i,
  input  logic [9:0]                pos_y_i,
  input  logic                      circle_start_i,
  input  logic [dldr_pkg::FIFO_CNT_W-1:0] fifo_count_i,
  output logic                      push_o,
  output dldr_pkg::job_t            job_o
);
  import dldr_pkg::*;

  localparam int CMP_W = IDX_W + 10;

  logic [7:0]       prev_q, prev_d;
  logic [IDX_W-1:0] rs_q, rs_d;
  logic [IDX_W-1:0] re_q, re_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic [9:0]       mid_q, mid_d;

  logic               accept;
  logic               first;
  logic               full;
  logic [IDX_W-1:0]   j_idx;
  logic               open_run;
  logic               ext_run;
  logic [IDX_W-1:0]   rs_n, re_n;
  logic [IDX_W-1:0]   diff;
  logic               report;
  logic [IDX_W:0]     mid_sum;
  logic [IDX_W-1:0]   mid_idx;
  logic [CMP_W-1:0]   mid_ext;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [STORE_W-1:0] rdata;
  logic [FIFO_CNT_W:0] used;

  // Hold input while the queue could not take one more report
  assign used       = {1'b0, fifo_count_i} + {{FIFO_CNT_W{1'b0}}, pend_q};
  assign in_stall_o = (used >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;

  assign first = circle_start_i || (cnt_q == '0);
  assign full  = (cnt_q == CNT_W'(MAX_CIRCLE_POINTS));
  assign j_idx = cnt_q[IDX_W-1:0];

  // Jump tests in 9 bits so that a negative lower bound never opens a run
  assign open_run = (({1'b0, gray_i} + {1'b0, cfg_i.jump_size}) < {1'b0, prev_q}) &&
                    (gray_i < cfg_i.dark_threshold);
  assign ext_run  = ({1'b0, gray_i} < ({1'b0, prev_q} + {1'b0, cfg_i.jump_size})) &&
                    (gray_i > cfg_i.floor_level);

  assign rs_n = open_run ? j_idx : rs_q;
  assign re_n = (open_run || ext_run) ? j_idx : re_q;
  assign diff = re_n - rs_n;

  assign report = (rs_n != '0) && (re_n >= rs_n) &&
                  ({{10{1'b0}}, diff} > {{IDX_W{1'b0}}, cfg_i.min_run_width});

  assign mid_sum = {1'b0, rs_n} + {1'b0, re_n};
  assign mid_idx = mid_sum[IDX_W:1];
  assign mid_ext = {{10{1'b0}}, mid_idx};

  // Update run state per accepted sample
  always_comb begin
    prev_d = prev_q;
    rs_d   = rs_q;
    re_d   = re_q;
    cnt_d  = cnt_q;
    pend_d = 1'b0;
    mid_d  = mid_q;
    we     = 1'b0;
    waddr  = j_idx;
    if (accept) begin
      if (first) begin
        we     = 1'b1;
        waddr  = '0;
        prev_d = gray_i;
        rs_d   = '0;
        re_d   = '0;
        cnt_d  = CNT_W'(1);
      end else if (!full) begin
        we     = 1'b1;
        prev_d = gray_i;
        cnt_d  = cnt_q + CNT_W'(1);
        if (report) begin
          rs_d   = '0;
          re_d   = '0;
          pend_d = 1'b1;
          mid_d  = mid_ext[9:0];
        end else begin
          rs_d = rs_n;
          re_d = re_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      rs_q   <= '0;
      re_q   <= '0;
      cnt_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      prev_q <= prev_d;
      rs_q   <= rs_d;
      re_q   <= re_d;
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
    end
  end

  // Midpoint index travels with the read
  always_ff @(posedge clk_i) begin
    mid_q <= mid_d;
  end

  // Circle buffer: write the sample, read the midpoint
  dldr_ram #(
    .WIDTH (STORE_W),
    .DEPTH (MAX_CIRCLE_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({pos_x_i, pos_y_i, gray_i}),
    .re_i    (pend_d),
    .raddr_i (mid_idx),
    .rdata_o (rdata)
  );

  // Queue the report once read data is back
  assign push_o          = pend_q;
  assign job_o.pos_x     = rdata[27:18];
  assign job_o.pos_y     = rdata[17:8];
  assign job_o.gray      = rdata[7:0];
  assign job_o.mid_index = mid_q;

endmodule

/* design/dldr_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dldr_fifo: report queue between front and back end
// Small register queue; the writer checks the count before it pushes.
// ----------------------------------------------------------------------------
module dldr_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  dldr_pkg::job_t                data_i,
  input  logic                          pop_i,
  output dldr_pkg::job_t                data_o,
  output logic                          not_empty_o,
  output logic [dldr_pkg::FIFO_CNT_W-1:0] count_o
);
  import dldr_pkg::*;

  job_t                  slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d;
  logic [FIFO_PTR_W-1:0] rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  // Advance pointers and count
  always_comb begin
    wr_d  = push_i ? wr_q + FIFO_PTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + FIFO_PTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + FIFO_CNT_W'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed reports
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  assign data_o      = slot_q[rd_q];
  assign not_empty_o = (cnt_q != '0);
  assign count_o     = cnt_q;

endmodule

/* design/dldr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dldr_back: distance and output stage
// Pops a report, squares the offsets from the centre, takes the floor square
// root one bit per cycle and hands the result to the output register.
// ----------------------------------------------------------------------------
module dldr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dldr_pkg::cfg_t cfg_i,
  input  logic           job_valid_i,
  input  dldr_pkg::job_t job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [9:0]     mid_x_o,
  output logic [9:0]     mid_y_o,
  output logic [9:0]     mid_index_o,
  output logic [10:0]    radius_o,
  output logic [7:0]     mark_value_o
);
  import dldr_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_ROOT = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [2:0]         state_q, state_d;
  job_t               job_q, job_d;
  logic signed [10:0] dx_q, dx_d;
  logic signed [10:0] dy_q, dy_d;
  logic [19:0]        sqx_q, sqx_d;
  logic [19:0]        sqy_q, sqy_d;
  logic [20:0]        v_q, v_d;
  logic [21:0]        res_q, res_d;
  logic [20:0]        bit_q, bit_d;
  logic               ov_q, ov_d;
  logic [9:0]         ox_q, ox_d;
  logic [9:0]         oy_q, oy_d;
  logic [9:0]         oi_q, oi_d;
  logic [10:0]        or_q, or_d;
  logic [7:0]         om_q, om_d;

  logic signed [21:0] px, py;
  logic [21:0]        trial;
  logic               slot_free;

  assign px        = dx_q * dx_q;
  assign py        = dy_q * dy_q;
  assign trial     = res_q + {1'b0, bit_q};
  assign slot_free = !ov_q || !out_stall_i;

  // Sequence one report through square, sum, root and output
  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    dx_d    = dx_q;
    dy_d    = dy_q;
    sqx_d   = sqx_q;
    sqy_d   = sqy_q;
    v_d     = v_q;
    res_d   = res_q;
    bit_d   = bit_q;
    ov_d    = ov_q && out_stall_i;
    ox_d    = ox_q;
    oy_d    = oy_q;
    oi_d    = oi_q;
    or_d    = or_q;
    om_d    = om_q;
    pop_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          dx_d    = $signed({1'b0, job_i.pos_x}) - $signed({1'b0, cfg_i.centre_x});
          dy_d    = $signed({1'b0, job_i.pos_y}) - $signed({1'b0, cfg_i.centre_y});
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        sqx_d   = px[19:0];
        sqy_d   = py[19:0];
        state_d = ST_SUM;
      end
      ST_SUM: begin
        v_d     = {1'b0, sqx_q} + {1'b0, sqy_q};
        res_d   = '0;
        bit_d   = 21'(1) << 20;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if ({1'b0, v_q} >= trial) begin
          v_d   = v_q - trial[20:0];
          res_d = (res_q >> 1) + {1'b0, bit_q};
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (bit_q == 21'd1) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          ox_d    = job_q.pos_x;
          oy_d    = job_q.pos_y;
          oi_d    = job_q.mid_index;
          or_d    = res_q[10:0];
          om_d    = (job_q.gray < MARK_DARK_LIMIT) ? MARK_ON : MARK_OFF;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    dx_q  <= dx_d;
    dy_q  <= dy_d;
    sqx_q <= sqx_d;
    sqy_q <= sqy_d;
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
    ox_q  <= ox_d;
    oy_q  <= oy_d;
    oi_q  <= oi_d;
    or_q  <= or_d;
    om_q  <= om_d;
  end

  assign out_valid_o  = ov_q;
  assign mid_x_o      = ox_q;
  assign mid_y_o      = oy_q;
  assign mid_index_o  = oi_q;
  assign radius_o     = or_q;
  assign mark_value_o = om_q;

endmodule

/* design/dark_light_dark_run_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dark_light_dark_run_detector: run detector along scan circles
// Finds dark-to-bright runs in circle samples and reports run midpoints with
// their distance from the image centre.
// ----------------------------------------------------------------------------
// The front end takes one sample per cycle unless stalled, buffers it in a
// 1024-entry circle RAM and tracks the run; a wide enough run reads its
// midpoint back from the RAM and puts a report into a four-entry queue. The
// back end takes each report through pop, square, sum, eleven square-root
// steps (one result bit per cycle) and the hand-off to the output register.
// Input stalls only while the queue, counting a report on its way in, is full,
// so with an idle back end a burst of up to five reports (one in the back end,
// four queued) passes at full sample rate; steady reports are paced by the back
// end, which pops a new one only once the last has gone to the output register.
// The circle RAM needs no clearing after reset. Configuration writes never stall.
// ----------------------------------------------------------------------------
module dark_light_dark_run_detector (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dldr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dldr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     gray_i,
  input  logic [9:0]                     pos_x_i,
  input  logic [9:0]                     pos_y_i,
  input  logic                           circle_start_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [9:0]                     mid_x_o,
  output logic [9:0]                     mid_y_o,
  output logic [9:0]                     mid_index_o,
  output logic [10:0]                    radius_o,
  output logic [7:0]                     mark_value_o
);
  import dldr_pkg::*;

  cfg_t                  cfg_q, cfg_d;
  logic                  push;
  job_t                  job_in;
  job_t                  job_out;
  logic                  pop;
  logic                  not_empty;
  logic [FIFO_CNT_W-1:0] fifo_count;

  assign cfg_ready_o = 1'b1;

  // Decode register writes; unknown indexes drop
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_JUMP_SIZE:      cfg_d.jump_size      = cfg_data_i[7:0];
        CFG_DARK_THRESHOLD: cfg_d.dark_threshold = cfg_data_i[7:0];
        CFG_FLOOR_LEVEL:    cfg_d.floor_level    = cfg_data_i[7:0];
        CFG_MIN_RUN_WIDTH:  cfg_d.min_run_width  = cfg_data_i;
        CFG_CENTRE_X:       cfg_d.centre_x       = cfg_data_i;
        CFG_CENTRE_Y:       cfg_d.centre_y       = cfg_data_i;
        default:            cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.jump_size      <= RST_JUMP_SIZE;
      cfg_q.dark_threshold <= RST_DARK_THRESHOLD;
      cfg_q.floor_level    <= RST_FLOOR_LEVEL;
      cfg_q.min_run_width  <= RST_MIN_RUN_WIDTH;
      cfg_q.centre_x       <= RST_CENTRE_X;
      cfg_q.centre_y       <= RST_CENTRE_Y;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dldr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .gray_i         (gray_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .circle_start_i (circle_start_i),
    .fifo_count_i   (fifo_count),
    .push_o         (push),
    .job_o          (job_in)
  );

  dldr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (job_in),
    .pop_i       (pop),
    .data_o      (job_out),
    .not_empty_o (not_empty),
    .count_o     (fifo_count)
  );

  dldr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .job_valid_i  (not_empty),
    .job_i        (job_out),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mid_x_o      (mid_x_o),
    .mid_y_o      (mid_y_o),
    .mid_index_o  (mid_index_o),
    .radius_o     (radius_o),
    .mark_value_o (mark_value_o)
  );

endmodule
